/* sv/vault_header_parser_assert.svh */
// Assertion macros shared by the vault header parser modules.
// Expects i_clk and i_rst_n in the including module's scope.
`ifndef VAULT_HEADER_PARSER_ASSERT_SVH
`define VAULT_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define VHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/vhp_pkg.sv */
// Types and constants for the vault header parser.
// No dependencies.
package vhp_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned STAT_W  = 4;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 41;

    localparam logic [31:0] MAGIC_WORD = 32'h4B4C_4549;

    // header byte positions that do not depend on salt and nonce sizes
    localparam int unsigned POS_MAGIC_END = 3;
    localparam int unsigned POS_VER_HI    = 4;
    localparam int unsigned POS_VERSION   = 5;
    localparam int unsigned POS_KDF       = 6;
    localparam int unsigned POS_OPS_FIRST = 7;
    localparam int unsigned POS_OPS       = 14;
    localparam int unsigned POS_MEM_FIRST = 15;
    localparam int unsigned POS_MEM       = 22;
    localparam int unsigned POS_PAR_FIRST = 23;
    localparam int unsigned POS_PAR       = 26;
    localparam int unsigned POS_SALT_LEN  = 27;
    localparam int unsigned POS_SALT0     = 28;

    localparam logic [STAT_W-1:0] ST_HEADER    = 4'd0;
    localparam logic [STAT_W-1:0] ST_ACCEPTED  = 4'd1;
    localparam logic [STAT_W-1:0] ST_PAYLOAD   = 4'd2;
    localparam logic [STAT_W-1:0] ST_BAD_MAGIC = 4'd3;
    localparam logic [STAT_W-1:0] ST_BAD_VER   = 4'd4;
    localparam logic [STAT_W-1:0] ST_BAD_KDF   = 4'd5;
    localparam logic [STAT_W-1:0] ST_BAD_OPS   = 4'd6;
    localparam logic [STAT_W-1:0] ST_BAD_MEM   = 4'd7;
    localparam logic [STAT_W-1:0] ST_BAD_PAR   = 4'd8;
    localparam logic [STAT_W-1:0] ST_BAD_SALT  = 4'd9;
    localparam logic [STAT_W-1:0] ST_BAD_NONCE = 4'd10;
    localparam logic [STAT_W-1:0] ST_TRUNC     = 4'd11;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 4'd12;

    localparam logic [KIND_W-1:0] FK_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] FK_VERSION = 3'd1;
    localparam logic [KIND_W-1:0] FK_KDF     = 3'd2;
    localparam logic [KIND_W-1:0] FK_OPS     = 3'd3;
    localparam logic [KIND_W-1:0] FK_MEMORY  = 3'd4;
    localparam logic [KIND_W-1:0] FK_PAR     = 3'd5;
    localparam logic [KIND_W-1:0] FK_SALT    = 3'd6;
    localparam logic [KIND_W-1:0] FK_NONCE   = 3'd7;

    localparam logic [CIDX_W-1:0] CFG_OPS_MIN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MEM_MIN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MEM_MAX = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_PAR_MAX = 2'd3;

    localparam logic [31:0] RST_OPS_MIN = 32'd1;
    localparam logic [30:0] RST_MEM_MIN = 31'd8192;
    localparam logic [40:0] RST_MEM_MAX = 41'd1 << 30;
    localparam logic [7:0]  RST_PAR_MAX = 8'd16;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_FAILED  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef struct packed {
        logic [31:0] ops_min;
        logic [30:0] mem_min;
        logic [40:0] mem_max;
        logic [7:0]  par_max;
    } t_cfg;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KIND_W-1:0]  kind;
        logic [ACC_W-1:0]   value;
        logic [INDEX_W-1:0] index;
    } t_result;

endpackage

/* sv/vhp_check.sv */
// Header parse state and the per-byte field check.
// Depends on vhp_pkg and vault_header_parser_assert.svh.
`include "vault_header_parser_assert.svh"

module vhp_check
    import vhp_pkg::*;
#(
    parameter int unsigned SALT_BYTES  = 16,
    parameter int unsigned NONCE_BYTES = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_sof,
    input  logic              i_eof,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    localparam int unsigned NONCE_LEN_I = POS_SALT0 + SALT_BYTES;
    localparam int unsigned NONCE0_I    = NONCE_LEN_I + 1;
    localparam int unsigned LAST_I      = NONCE0_I + NONCE_BYTES - 1;
    localparam int unsigned POS_W       = $clog2(LAST_I + 1);

    localparam logic [POS_W-1:0] LP_MAGIC_END = POS_W'(POS_MAGIC_END);
    localparam logic [POS_W-1:0] LP_VER_HI    = POS_W'(POS_VER_HI);
    localparam logic [POS_W-1:0] LP_VERSION   = POS_W'(POS_VERSION);
    localparam logic [POS_W-1:0] LP_KDF       = POS_W'(POS_KDF);
    localparam logic [POS_W-1:0] LP_OPS_FIRST = POS_W'(POS_OPS_FIRST);
    localparam logic [POS_W-1:0] LP_OPS       = POS_W'(POS_OPS);
    localparam logic [POS_W-1:0] LP_MEM_FIRST = POS_W'(POS_MEM_FIRST);
    localparam logic [POS_W-1:0] LP_MEM       = POS_W'(POS_MEM);
    localparam logic [POS_W-1:0] LP_PAR_FIRST = POS_W'(POS_PAR_FIRST);
    localparam logic [POS_W-1:0] LP_PAR       = POS_W'(POS_PAR);
    localparam logic [POS_W-1:0] LP_SALT_LEN  = POS_W'(POS_SALT_LEN);
    localparam logic [POS_W-1:0] LP_SALT0     = POS_W'(POS_SALT0);
    localparam logic [POS_W-1:0] LP_NONCE_LEN = POS_W'(NONCE_LEN_I);
    localparam logic [POS_W-1:0] LP_NONCE0    = POS_W'(NONCE0_I);
    localparam logic [POS_W-1:0] LP_LAST      = POS_W'(LAST_I);

    localparam logic [DATA_W-1:0] SALT_LEN_B  = DATA_W'(SALT_BYTES);
    localparam logic [DATA_W-1:0] NONCE_LEN_B = DATA_W'(NONCE_BYTES);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    t_phase           r_phase;
    t_phase           n_phase;

    t_phase           eff_phase;
    logic [POS_W-1:0] pos;
    logic [ACC_W-1:0] acc_old;
    logic [ACC_W-1:0] acc;
    logic [POS_W-1:0] salt_off;
    logic [POS_W-1:0] nonce_off;
    logic             mid_field;
    logic             done;
    logic             last;
    t_result          res;

    // result for the byte in flight
    always_comb begin
        eff_phase = i_sof ? PH_HEADER : r_phase;
        pos       = i_sof ? '0 : r_pos;
        acc_old   = i_sof ? '0 : r_acc;
        acc       = {acc_old[ACC_W-DATA_W-1:0], i_data_byte};
        salt_off  = pos - LP_SALT0;
        nonce_off = pos - LP_NONCE0;
        mid_field = (pos < LP_MAGIC_END) || (pos == LP_VER_HI)
                 || (pos >= LP_OPS_FIRST && pos < LP_OPS)
                 || (pos >= LP_MEM_FIRST && pos < LP_MEM)
                 || (pos >= LP_PAR_FIRST && pos < LP_PAR);
        res       = '0;
        done      = 1'b1;
        last      = 1'b0;
        unique case (eff_phase)
            PH_FAILED: begin
                res.status = ST_IGNORED;
            end
            PH_PAYLOAD: begin
                res.status = ST_PAYLOAD;
            end
            PH_HEADER: begin
                if (mid_field) begin
                    done = 1'b0;
                end else if (pos == LP_MAGIC_END) begin
                    if (acc[31:0] != MAGIC_WORD) res.status = ST_BAD_MAGIC;
                end else if (pos == LP_VERSION) begin
                    res.kind  = FK_VERSION;
                    res.value = {48'd0, acc[15:0]};
                    if (acc[15:0] != 16'd1) res.status = ST_BAD_VER;
                end else if (pos == LP_KDF) begin
                    res.kind  = FK_KDF;
                    res.value = {56'd0, i_data_byte};
                    if (i_data_byte != 8'd1) res.status = ST_BAD_KDF;
                end else if (pos == LP_OPS) begin
                    res.kind  = FK_OPS;
                    res.value = acc;
                    if (acc < {32'd0, i_cfg.ops_min}) res.status = ST_BAD_OPS;
                end else if (pos == LP_MEM) begin
                    res.kind  = FK_MEMORY;
                    res.value = acc;
                    if (acc < {33'd0, i_cfg.mem_min} || acc > {23'd0, i_cfg.mem_max}) begin
                        res.status = ST_BAD_MEM;
                    end
                end else if (pos == LP_PAR) begin
                    res.kind  = FK_PAR;
                    res.value = {32'd0, acc[31:0]};
                    if (acc[31:0] == 32'd0 || acc[31:0] > {24'd0, i_cfg.par_max}) begin
                        res.status = ST_BAD_PAR;
                    end
                end else if (pos == LP_SALT_LEN) begin
                    if (i_data_byte != SALT_LEN_B) res.status = ST_BAD_SALT;
                end else if (pos < LP_NONCE_LEN) begin
                    res.kind  = FK_SALT;
                    res.value = {56'd0, i_data_byte};
                    res.index = salt_off[INDEX_W-1:0];
                end else if (pos == LP_NONCE_LEN) begin
                    if (i_data_byte != NONCE_LEN_B) res.status = ST_BAD_NONCE;
                end else begin
                    res.kind  = FK_NONCE;
                    res.value = {56'd0, i_data_byte};
                    res.index = nonce_off[INDEX_W-1:0];
                    last      = (pos >= LP_LAST);
                end
                if (res.status == ST_HEADER) begin
                    if (last) begin
                        res.status = ST_ACCEPTED;
                    end else if (i_eof) begin
                        res.status = ST_TRUNC;
                    end
                end
            end
            default: begin
                res.status = ST_IGNORED;
            end
        endcase
    end

    // next parse state
    always_comb begin
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_phase = r_phase;
        if (eff_phase == PH_HEADER) begin
            n_acc   = done ? '0 : acc;
            n_pos   = pos;
            n_phase = PH_HEADER;
            if (res.status == ST_ACCEPTED) begin
                n_phase = PH_PAYLOAD;
            end else if (res.status != ST_HEADER) begin
                n_phase = PH_FAILED;
            end else begin
                n_pos = pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_acc   <= '0;
            r_phase <= PH_HEADER;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_phase <= n_phase;
        end
    end

    assign o_result = res;

    `VHP_ASSERT_NOW(a_pos_in_header, 1'b1, r_pos <= LP_LAST, "header position overran")
    `VHP_ASSERT_NEXT(a_payload_holds, i_fire && eff_phase == PH_PAYLOAD,
        r_phase == PH_PAYLOAD, "payload phase left without start of file")
    `VHP_ASSERT_NEXT(a_trunc_fails, i_fire && res.status == ST_TRUNC,
        r_phase == PH_FAILED, "truncation did not latch failure")

endmodule

/* sv/vhp_out_buf.sv */
// Two-entry result buffer between the check stage and the output channel.
// Depends on vhp_pkg and vault_header_parser_assert.svh.
`include "vault_header_parser_assert.svh"

module vhp_out_buf
    import vhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    t_result     r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop) r_rd_ptr <= ~r_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    `VHP_ASSERT_NOW(a_count_range, 1'b1, r_count <= 2'd2, "buffer count out of range")
    `VHP_ASSERT_NOW(a_no_overflow, i_push, r_count != 2'd2, "push into full buffer")
    `VHP_ASSERT_NEXT(a_drain, pop && !i_push, r_count == $past(r_count) - 2'd1,
        "transfer out did not drain an entry")

endmodule

/* sv/vault_header_parser.sv */
// Vault file header parser. Takes one file byte per transfer and returns one result per
// byte, offered after it passes the input register and the result buffer. Sustained rate
// is one byte per clock while o_in_stall is low, set by the combinational field check
// between the input register and the two-entry result buffer; o_in_stall rises only while
// that buffer is full and a byte is waiting in the input register. Configuration is to be
// written through the cfg port only while no byte is in flight, which the block does not
// enforce; o_cfg_ready is always high. Depends on vhp_pkg, vhp_check and vhp_out_buf.
module vault_header_parser
    import vhp_pkg::*;
#(
    parameter int unsigned SALT_BYTES  = 16,
    parameter int unsigned NONCE_BYTES = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DATA_W-1:0]  i_data_byte,
    input  logic               i_start_of_file,
    input  logic               i_end_of_file,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [KIND_W-1:0]  o_field_kind,
    output logic [ACC_W-1:0]   o_field_value,
    output logic [INDEX_W-1:0] o_field_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CDATA_W-1:0] i_cfg_data
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_in_sof;
    logic              r_in_eof;
    logic              in_fire;
    logic              advance;
    logic              buf_full;
    t_result           check_res;
    t_result           out_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid && buf_full;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign advance     = r_in_valid && !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ops_min <= RST_OPS_MIN;
            r_cfg.mem_min <= RST_MEM_MIN;
            r_cfg.mem_max <= RST_MEM_MAX;
            r_cfg.par_max <= RST_PAR_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OPS_MIN: r_cfg.ops_min <= i_cfg_data[31:0];
                CFG_MEM_MIN: r_cfg.mem_min <= i_cfg_data[30:0];
                CFG_MEM_MAX: r_cfg.mem_max <= i_cfg_data[40:0];
                CFG_PAR_MAX: r_cfg.par_max <= i_cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_data_byte;
            r_in_sof  <= i_start_of_file;
            r_in_eof  <= i_end_of_file;
        end
    end

    vhp_check #(
        .SALT_BYTES  (SALT_BYTES),
        .NONCE_BYTES (NONCE_BYTES)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_data_byte (r_in_byte),
        .i_sof       (r_in_sof),
        .i_eof       (r_in_eof),
        .i_cfg       (r_cfg),
        .o_result    (check_res)
    );

    vhp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (check_res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_status      = out_res.status;
    assign o_field_kind  = out_res.kind;
    assign o_field_value = out_res.value;
    assign o_field_index = out_res.index;

endmodule
